### rtl/core/bos_pkg.sv
// Package for the bounded overwrite stack: built sizes, operation codes
// and the stage record passed down the read pipeline.
// No dependencies.
package bos_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int SIZE_W     = $clog2(DEPTH + 1);
    localparam int CFG_W      = 5;
    localparam int FUNC_W     = 2;
    localparam int FILL_W     = 5;
    localparam int CMP_W      = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
    localparam int SIZE_RESET = (16 < DEPTH) ? 16 : DEPTH;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PULL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

    // Operation waiting for its slot read to return
    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] fill;
    } t_rd_stage;

endpackage

### rtl/core/bos_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module bos_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bounded_overwrite_stack.sv
// Bounded LIFO stack in a ring of RAM slots; push overwrites the oldest word.
// Accepted operations pass the RAM read stage, then the output register.
// Throughput: one operation per cycle unless the input is stalled; the top and
// fill counters update at accept and the RAM read port serves pull and peek.
// Reset (sync, active low) and a size write empty the stack; slots keep data.
// Depends on bos_pkg and bos_ram.
module bounded_overwrite_stack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bos_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bos_pkg::FUNC_W-1:0]  i_func,
    input  logic [bos_pkg::DATA_W-1:0]  i_push_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bos_pkg::DATA_W-1:0]  o_top_value,
    output logic                        o_found,
    output logic [bos_pkg::FILL_W-1:0]  o_fill_count
);

    localparam int IDX_W  = bos_pkg::IDX_W;
    localparam int SIZE_W = bos_pkg::SIZE_W;
    localparam int CMP_W  = bos_pkg::CMP_W;

    logic [SIZE_W-1:0] r_size, n_size;
    logic [IDX_W-1:0]  r_top,  n_top;
    logic [SIZE_W-1:0] r_occ,  n_occ;

    logic                 r_rd_valid, n_rd_valid;
    bos_pkg::t_rd_stage   r_rd, n_rd;

    logic                        r_out_valid, n_out_valid;
    logic [bos_pkg::DATA_W-1:0]  r_out_value;
    logic                        r_out_found;
    logic [SIZE_W-1:0]           r_out_fill;

    logic                       out_free, rd_move, accept;
    logic                       ram_we, ram_re;
    logic [IDX_W-1:0]           ram_waddr;
    logic [bos_pkg::DATA_W-1:0] ram_rdata;
    logic [CMP_W-1:0]           cfg_ext;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign rd_move    = r_rd_valid && out_free;
    assign o_in_stall = r_rd_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign cfg_ext = CMP_W'(i_cfg_data);

    always_comb begin
        n_size    = r_size;
        n_top     = r_top;
        n_occ     = r_occ;
        n_rd      = r_rd;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_top;

        if (i_cfg_we) begin
            // clamp the size into 1..DEPTH and empty the stack
            if (i_cfg_data == '0) begin
                n_size = SIZE_W'(1);
            end else if (cfg_ext > CMP_W'(bos_pkg::DEPTH)) begin
                n_size = SIZE_W'(bos_pkg::DEPTH);
            end else begin
                n_size = SIZE_W'(cfg_ext);
            end
            n_top = IDX_W'(n_size - 1'b1);
            n_occ = '0;
        end else if (accept) begin
            n_rd.found = 1'b0;
            case (i_func)
                bos_pkg::FUNC_PUSH: begin
                    if (SIZE_W'(r_top) + 1'b1 == r_size) begin
                        n_top = '0;
                    end else begin
                        n_top = r_top + 1'b1;
                    end
                    if (r_occ < r_size) begin
                        n_occ = r_occ + 1'b1;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = n_top;
                end
                bos_pkg::FUNC_PULL: begin
                    if (r_occ != '0) begin
                        n_rd.found = 1'b1;
                        ram_re     = 1'b1;
                        n_occ      = r_occ - 1'b1;
                        if (r_top == '0) begin
                            n_top = IDX_W'(r_size - 1'b1);
                        end else begin
                            n_top = r_top - 1'b1;
                        end
                    end
                end
                bos_pkg::FUNC_PEEK: begin
                    if (r_occ != '0) begin
                        n_rd.found = 1'b1;
                        ram_re     = 1'b1;
                    end
                end
                default: begin
                    n_rd.found = 1'b0;
                end
            endcase
            n_rd.fill = n_occ;
        end
    end

    always_comb begin
        n_rd_valid = r_rd_valid;
        if (rd_move) begin
            n_rd_valid = 1'b0;
        end
        if (accept) begin
            n_rd_valid = 1'b1;
        end
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_rd_valid;
        end
    end

    bos_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (bos_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_push_value),
        .i_re    (ram_re),
        .i_raddr (r_top),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_W'(bos_pkg::SIZE_RESET);
            r_top       <= IDX_W'(bos_pkg::SIZE_RESET - 1);
            r_occ       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_size      <= n_size;
            r_top       <= n_top;
            r_occ       <= n_occ;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: hold the stage record until it moves on
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= n_rd;
        end
        if (rd_move) begin
            r_out_value <= r_rd.found ? ram_rdata : '0;
            r_out_found <= r_rd.found;
            r_out_fill  <= r_rd.fill;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_top_value  = r_out_value;
    assign o_found      = r_out_found;
    assign o_fill_count = bos_pkg::FILL_W'(r_out_fill);

endmodule

### rtl/core/bos_checker.sv
// Port-level checks for the bounded overwrite stack, bound to the top level.
// Depends on bos_pkg and bounded_overwrite_stack.
module bos_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [bos_pkg::DATA_W-1:0]  o_top_value,
    input logic                        o_found,
    input logic [bos_pkg::FILL_W-1:0]  o_fill_count
);

    // no word is shown in the cycle after a reset edge
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // input back-pressure only while a result waits on a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // a missed lookup carries a zero word; fill never passes the depth
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_found || o_top_value == '0)
                         && o_fill_count <= bos_pkg::FILL_W'(bos_pkg::DEPTH)))
        else $error("malformed result word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_top_value)
                                          && $stable(o_found) && $stable(o_fill_count)))
        else $error("stalled result changed");

endmodule

bind bounded_overwrite_stack bos_checker u_bos_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_top_value  (o_top_value),
    .o_found      (o_found),
    .o_fill_count (o_fill_count)
);
